// ===== hdl/iat_pkg.sv =====
// types, codes and character constants shared by the indent-aware tokenizer
// used by iat_scan, iat_emit and indent_aware_tokenizer; no dependencies
package iat_pkg;

	typedef enum logic [3:0] {
		TK_INDENT  = 4'd0,
		TK_DEDENT  = 4'd1,
		TK_NEWLINE = 4'd2,
		TK_EOF     = 4'd3,
		TK_PLUS    = 4'd4,
		TK_MINUS   = 4'd5,
		TK_LPAREN  = 4'd6,
		TK_RPAREN  = 4'd7,
		TK_COLON   = 4'd8,
		TK_STRING  = 4'd9,
		TK_DEF     = 4'd10,
		TK_NUMBER  = 4'd11,
		TK_IDENT   = 4'd12
	} tok_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_TAB_MID     = 3'd1,
		ERR_OPEN_STRING = 3'd2,
		ERR_LEAD_ZERO   = 3'd3,
		ERR_DIGIT_IDENT = 3'd4,
		ERR_INDENT_OVF  = 3'd5
	} err_code_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_STR  = 2'd2
	} scan_mode_t;

	// largest supported indent depth, sets the dedent count width
	localparam int MAX_INDENT_LIMIT = 63;
	localparam int DCNT_W = $clog2(MAX_INDENT_LIMIT + 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// everything the results of one source byte need, in emission order:
	// optional word token, a run of dedents, optional final token
	typedef struct packed {
		logic              has_word;
		tok_kind_t         word_kind;
		logic [15:0]       word_start;
		logic [15:0]       word_len;
		logic [DCNT_W-1:0] dedents;
		logic [15:0]       dedent_start;
		logic              has_final;
		tok_kind_t         final_kind;
		logic [15:0]       final_start;
		logic [15:0]       final_len;
		err_code_t         final_err;
		logic [15:0]       line;
	} rslt_desc_t;

	function automatic logic [7:0] kw_def_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h64;
			2'd1: ch = 8'h65;
			2'd2: ch = 8'h66;
			default: ch = CH_NUL;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

	function automatic logic is_delim(input logic [7:0] ch);
		return (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_LPAREN) ||
			(ch == CH_RPAREN) || (ch == CH_COLON) || (ch == CH_QUOTE) ||
			(ch == CH_TAB) || (ch == CH_NUL) || (ch == CH_PLUS) ||
			(ch == CH_MINUS);
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

// ===== hdl/indent_aware_tokenizer.sv =====
// Indent-aware tokenizer, top level.
// Source bytes come in on the source channel (source_valid/source_ready,
// payload source_char), one byte per request; a zero byte marks end of input.
// Tokens leave on the token channel (token_valid/token_ready) with kind,
// start offset, length, line, error code and last_of_run, which flags the
// final token caused by one source byte.
// The first token of a byte passes through the descriptor register in
// iat_emit before it is loaded into the output register.
// Throughput: one byte per cycle while token_ready is high and each byte
// gives at most one token. A byte giving N tokens (word and final token,
// or dedents and a final token, up to MAX_INDENT + 1) loads them in turn; the
// next byte, whether it gives tokens or not, waits until the last is loaded.
// When token_ready is low the output register holds and one descriptor
// waits behind it, after which source_ready drops.
// Reset clears indent depth, line and offset counters and the halt flag.
// After an error token the block keeps taking bytes but emits nothing
// until reset.
// Depends on iat_pkg, iat_scan and iat_emit.
module indent_aware_tokenizer #(
	parameter int MAX_INDENT  = 16,
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        source_valid,
	output logic        source_ready,
	input  logic [7:0]  source_char,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] line_number,
	output logic [2:0]  error_code,
	output logic        last_of_run
);
	import iat_pkg::*;

	rslt_desc_t desc;
	logic       desc_has;
	logic       room;
	logic       fire;

	assign source_ready = room;
	assign fire         = source_valid && room;

	iat_scan #(
		.MAX_INDENT  (MAX_INDENT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.source_char (source_char),
		.desc        (desc),
		.desc_has    (desc_has)
	);

	iat_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (fire && desc_has),
		.desc         (desc),
		.room         (room),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.line_number  (line_number),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== hdl/iat_scan.sv =====
// scanner state and per-byte decode: updates indent, word and line state on
// each accepted byte and builds the result descriptor; uses iat_pkg
module iat_scan #(
	parameter int MAX_INDENT  = 16,
	parameter int OFFSET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         source_char,
	output iat_pkg::rslt_desc_t desc,
	output logic               desc_has
);
	import iat_pkg::*;

	localparam int DEP_W = $clog2(MAX_INDENT + 1);
	localparam int OFF_W = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
	localparam logic [DEP_W-1:0] DEPTH_MAX = DEP_W'(MAX_INDENT);
	localparam logic [OFF_W-1:0] OFF_LIMIT = '1;

	logic [DEP_W-1:0] depth_q, n_depth;
	logic [DEP_W-1:0] tabs_q, n_tabs;
	logic             line_start_q, n_line_start;
	scan_mode_t       mode_q, n_mode;
	logic [15:0]      wlen_q, n_wlen;
	logic             all_dig_q, n_all_dig;
	logic             lead_dig_q, n_lead_dig;
	logic             lead_zero_q, n_lead_zero;
	logic [1:0]       kw_q, n_kw;
	logic [15:0]      line_q, n_line;
	logic [OFF_W-1:0] off_q, n_off;
	logic [OFF_W-1:0] ots_q, n_ots;
	logic             halted_q, n_halted;
	logic             go;
	logic [15:0]      pos16;
	logic [15:0]      ots16;
	logic [15:0]      wlen_inc;
	logic             kw_hit;

	assign pos16    = 16'(off_q);
	assign ots16    = 16'(ots_q);
	assign wlen_inc = sat_inc16(wlen_q);
	assign kw_hit   = (kw_q != 2'd3) && (16'(kw_q) == wlen_q) &&
		(source_char == kw_def_char(kw_q));

	always_comb begin
		n_depth      = depth_q;
		n_tabs       = tabs_q;
		n_line_start = line_start_q;
		n_mode       = mode_q;
		n_wlen       = wlen_q;
		n_all_dig    = all_dig_q;
		n_lead_dig   = lead_dig_q;
		n_lead_zero  = lead_zero_q;
		n_kw         = kw_q;
		n_line       = line_q;
		n_off        = off_q;
		n_ots        = ots_q;
		n_halted     = halted_q;
		go           = 1'b0;
		desc              = '0;
		desc.line         = line_q;
		desc.dedent_start = pos16;
		desc.word_start   = ots16;

		if (!halted_q) begin
			if (off_q != OFF_LIMIT) begin
				n_off = off_q + 1'b1;
			end
			case (mode_q)
				MODE_STR: begin
					if (source_char == CH_QUOTE) begin
						n_wlen           = wlen_inc;
						desc.has_final   = 1'b1;
						desc.final_kind  = TK_STRING;
						desc.final_start = ots16;
						desc.final_len   = wlen_inc;
						n_mode           = MODE_IDLE;
					end else if (source_char == CH_NUL || source_char == CH_LF) begin
						desc.has_final   = 1'b1;
						desc.final_kind  = TK_INDENT;
						desc.final_start = ots16;
						desc.final_err   = ERR_OPEN_STRING;
						n_halted         = 1'b1;
					end else begin
						n_wlen = wlen_inc;
					end
				end
				MODE_WORD: begin
					if (!is_delim(source_char)) begin
						if (kw_hit) begin
							n_kw = kw_q + 2'd1;
						end
						n_all_dig = all_dig_q & is_digit(source_char);
						n_wlen    = wlen_inc;
					end else begin
						n_mode = MODE_IDLE;
						go     = 1'b1;
						desc.word_len = wlen_q;
						if (wlen_q == 16'd3 && kw_q == 2'd3) begin
							desc.has_word  = 1'b1;
							desc.word_kind = TK_DEF;
						end else if (all_dig_q && lead_zero_q) begin
							desc.has_final   = 1'b1;
							desc.final_kind  = TK_INDENT;
							desc.final_start = ots16;
							desc.final_err   = ERR_LEAD_ZERO;
							n_halted         = 1'b1;
							go               = 1'b0;
						end else if (all_dig_q) begin
							desc.has_word  = 1'b1;
							desc.word_kind = TK_NUMBER;
						end else if (lead_dig_q) begin
							desc.has_final   = 1'b1;
							desc.final_kind  = TK_INDENT;
							desc.final_start = ots16;
							desc.final_err   = ERR_DIGIT_IDENT;
							n_halted         = 1'b1;
							go               = 1'b0;
						end else begin
							desc.has_word  = 1'b1;
							desc.word_kind = TK_IDENT;
						end
					end
				end
				default: begin
					go = 1'b1;
				end
			endcase

			// byte starts fresh: spaces, tabs, punctuation, new word or string
			if (go && source_char != CH_SPACE) begin
				desc.final_start = pos16;
				desc.final_len   = 16'd1;
				if (source_char == CH_TAB) begin
					if (!line_start_q) begin
						desc.has_final = 1'b1;
						desc.final_kind = TK_INDENT;
						desc.final_len  = 16'd0;
						desc.final_err  = ERR_TAB_MID;
						n_halted        = 1'b1;
					end else if (tabs_q < depth_q) begin
						n_tabs = tabs_q + 1'b1;
					end else if (depth_q >= DEPTH_MAX) begin
						desc.has_final = 1'b1;
						desc.final_kind = TK_INDENT;
						desc.final_len  = 16'd0;
						desc.final_err  = ERR_INDENT_OVF;
						n_halted        = 1'b1;
					end else begin
						desc.has_final  = 1'b1;
						desc.final_kind = TK_INDENT;
						n_depth         = depth_q + 1'b1;
						n_tabs          = tabs_q + 1'b1;
					end
				end else begin
					if (tabs_q < depth_q) begin
						desc.dedents = DCNT_W'(depth_q - tabs_q);
						n_depth      = tabs_q;
					end
					n_line_start = 1'b0;
					case (source_char)
						CH_NUL: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_EOF;
							desc.final_len  = 16'd0;
							n_line_start    = 1'b1;
						end
						CH_LF: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_NEWLINE;
							n_line          = sat_inc16(line_q);
							n_tabs          = '0;
							n_line_start    = 1'b1;
						end
						CH_PLUS: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_PLUS;
						end
						CH_MINUS: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_MINUS;
						end
						CH_LPAREN: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_LPAREN;
						end
						CH_RPAREN: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_RPAREN;
						end
						CH_COLON: begin
							desc.has_final  = 1'b1;
							desc.final_kind = TK_COLON;
						end
						CH_QUOTE: begin
							n_mode = MODE_STR;
							n_ots  = off_q;
							n_wlen = 16'd1;
						end
						default: begin
							n_mode      = MODE_WORD;
							n_ots       = off_q;
							n_wlen      = 16'd1;
							n_kw        = (source_char == kw_def_char(2'd0)) ? 2'd1 : 2'd0;
							n_all_dig   = is_digit(source_char);
							n_lead_dig  = is_digit(source_char);
							n_lead_zero = (source_char == CH_ZERO);
						end
					endcase
				end
			end
		end
	end

	assign desc_has = desc.has_word | (desc.dedents != '0) | desc.has_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			tabs_q       <= '0;
			line_start_q <= 1'b1;
			mode_q       <= MODE_IDLE;
			wlen_q       <= '0;
			all_dig_q    <= 1'b1;
			lead_dig_q   <= 1'b0;
			lead_zero_q  <= 1'b0;
			kw_q         <= '0;
			line_q       <= '0;
			off_q        <= '0;
			ots_q        <= '0;
			halted_q     <= 1'b0;
		end else if (fire) begin
			depth_q      <= n_depth;
			tabs_q       <= n_tabs;
			line_start_q <= n_line_start;
			mode_q       <= n_mode;
			wlen_q       <= n_wlen;
			all_dig_q    <= n_all_dig;
			lead_dig_q   <= n_lead_dig;
			lead_zero_q  <= n_lead_zero;
			kw_q         <= n_kw;
			line_q       <= n_line;
			off_q        <= n_off;
			ots_q        <= n_ots;
			halted_q     <= n_halted;
		end
	end

`ifndef SYNTHESIS
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("tokenizer left the halted state without reset");
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !desc_has)
		else $error("results produced while halted");
	a_tabs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tabs_q <= depth_q) && (depth_q <= DEPTH_MAX))
		else $error("tab count or indent depth out of range");
`endif

endmodule

// ===== hdl/iat_emit.sv =====
// result sequencer: holds one byte's result descriptor and plays it out as
// word token, dedent run and final token through an output register; uses iat_pkg
module iat_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  iat_pkg::rslt_desc_t desc,
	output logic                room,
	output logic                token_valid,
	input  logic                token_ready,
	output logic [3:0]          token_kind,
	output logic [15:0]         token_start,
	output logic [15:0]         token_length,
	output logic [15:0]         line_number,
	output logic [2:0]          error_code,
	output logic                last_of_run
);
	import iat_pkg::*;

	rslt_desc_t        desc_s1;
	logic              word_pend_q;
	logic [DCNT_W-1:0] ded_left_q;
	logic              final_pend_q;
	logic              any_pend;
	logic              last_pend;
	logic              out_load;
	logic              pop;
	logic              valid_q;
	tok_kind_t         kind_q;
	logic [15:0]       start_q;
	logic [15:0]       len_q;
	logic [15:0]       line_q;
	err_code_t         err_q;
	logic              last_q;

	assign any_pend  = word_pend_q | (ded_left_q != '0) | final_pend_q;
	assign last_pend = (word_pend_q && ded_left_q == '0 && !final_pend_q) ||
		(!word_pend_q && ded_left_q == DCNT_W'(1) && !final_pend_q) ||
		(!word_pend_q && ded_left_q == '0 && final_pend_q);
	assign out_load  = !valid_q || token_ready;
	assign pop       = out_load && any_pend;
	assign room      = !any_pend || (pop && last_pend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pend_q  <= 1'b0;
			ded_left_q   <= '0;
			final_pend_q <= 1'b0;
		end else if (push && room) begin
			word_pend_q  <= desc.has_word;
			ded_left_q   <= desc.dedents;
			final_pend_q <= desc.has_final;
		end else if (pop) begin
			if (word_pend_q) begin
				word_pend_q <= 1'b0;
			end else if (ded_left_q != '0) begin
				ded_left_q <= ded_left_q - 1'b1;
			end else begin
				final_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && room) begin
			desc_s1 <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load) begin
			valid_q <= any_pend;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			line_q <= desc_s1.line;
			last_q <= last_pend;
			if (word_pend_q) begin
				kind_q  <= desc_s1.word_kind;
				start_q <= desc_s1.word_start;
				len_q   <= desc_s1.word_len;
				err_q   <= ERR_NONE;
			end else if (ded_left_q != '0) begin
				kind_q  <= TK_DEDENT;
				start_q <= desc_s1.dedent_start;
				len_q   <= 16'd0;
				err_q   <= ERR_NONE;
			end else begin
				kind_q  <= desc_s1.final_kind;
				start_q <= desc_s1.final_start;
				len_q   <= desc_s1.final_len;
				err_q   <= desc_s1.final_err;
			end
		end
	end

	assign token_valid  = valid_q;
	assign token_kind   = kind_q;
	assign token_start  = start_q;
	assign token_length = len_q;
	assign line_number  = line_q;
	assign error_code   = err_q;
	assign last_of_run  = last_q;

`ifndef SYNTHESIS
	a_dedent_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !word_pend_q && ded_left_q > DCNT_W'(1) && !push) |=>
		(ded_left_q == $past(ded_left_q) - 1'b1))
		else $error("dedent run count did not step by one");
	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && last_pend && !push) |=> !any_pend)
		else $error("descriptor not empty after its last result");
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && err_q != ERR_NONE) |-> last_q)
		else $error("error result not marked last of its run");
`endif

endmodule
